FILE: hdl/bgpe_pkg.sv
// ----------------------------------------------------------------------------
// bgpe_pkg
// Shared types, codes and constants of the glyph pixel emitter.
// ----------------------------------------------------------------------------
package bgpe_pkg;

	// item codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_BYTE  = 1'b1;

	// register indexes
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	localparam logic [10:0] SCREEN_WIDTH_RST  = 11'd384;
	localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd216;
	localparam logic [10:0] COORD_LIMIT       = 11'd1024;

	// command queue between front and back
	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	typedef logic signed [17:0] coord_t;

	// one classified item in the command queue
	typedef struct packed {
		logic        is_byte;
		coord_t      col;
		coord_t      row;
		logic [7:0]  width;
		logic [7:0]  rows;
		logic [15:0] color;
		logic [7:0]  data;
	} op_t;

	// one pixel write
	typedef struct packed {
		logic [9:0]  x;
		logic [9:0]  y;
		logic [15:0] color;
		logic        last;
	} pix_t;

	// visible area, already clamped to the coordinate range
	typedef struct packed {
		logic [10:0] wlim;
		logic [10:0] hlim;
	} limits_t;

	function automatic logic [10:0] clamp_limit(input logic [10:0] reg_val);
		clamp_limit = (reg_val > COORD_LIMIT) ? COORD_LIMIT : reg_val;
	endfunction

endpackage

FILE: hdl/bgpe_front.sv
// ----------------------------------------------------------------------------
// bgpe_front
// Input side: accepts items, works out the glyph origin for start items and
// writes one classified entry per item into the command queue.
// ----------------------------------------------------------------------------
module bgpe_front
	import bgpe_pkg::*;
(
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [15:0] pen_x,
	input  logic [15:0] pen_y,
	input  logic [7:0]  glyph_cols,
	input  logic [7:0]  glyph_height,
	input  logic [7:0]  offset_x,
	input  logic [7:0]  offset_y,
	input  logic [7:0]  line_advance,
	input  logic [15:0] ink_color,
	input  logic [7:0]  bitmap_byte,
	input  logic        q_full,
	output logic        q_wr,
	output op_t         q_wdata
);

	coord_t col_sum;
	coord_t row_sum;

	// origin column and row, sign extended to the coordinate width
	assign col_sum = {{2{pen_x[15]}}, pen_x} + {{10{offset_x[7]}}, offset_x};
	assign row_sum = {{2{pen_y[15]}}, pen_y} + {{10{offset_y[7]}}, offset_y}
		+ {10'b0, line_advance};

	assign full = q_full;
	assign q_wr = push && !q_full;

	// a zero-width glyph has no rows to walk
	always_comb begin
		q_wdata.is_byte = (cmd == CMD_BYTE);
		q_wdata.col     = col_sum;
		q_wdata.row     = row_sum;
		q_wdata.width   = glyph_cols;
		q_wdata.rows    = (glyph_cols == 8'd0) ? 8'd0 : glyph_height;
		q_wdata.color   = ink_color;
		q_wdata.data    = bitmap_byte;
	end

endmodule

FILE: hdl/bgpe_cmd_queue.sv
// ----------------------------------------------------------------------------
// bgpe_cmd_queue
// Small FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module bgpe_cmd_queue
	import bgpe_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  op_t    wr_data,
	output logic   q_full,
	input  logic   rd_en,
	output op_t    rd_data,
	output logic   q_empty
);

	op_t            mem_q [QDepth];
	logic [QAw-1:0] wr_ptr_q;
	logic [QAw-1:0] rd_ptr_q;
	logic [QAw:0]   cnt_q;

	assign q_full  = (cnt_q == (QAw+1)'(QDepth));
	assign q_empty = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/bgpe_back.sv
// ----------------------------------------------------------------------------
// bgpe_back
// Bit walker: takes items from the command queue, steps one bitmap bit per
// cycle while the output buffer has space, clips against the screen, queues
// pixel writes; one pixel is held back so a byte's final write can be marked.
// ----------------------------------------------------------------------------
module bgpe_back
	import bgpe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  limits_t     lim,
	input  op_t         q_rdata,
	input  logic        q_empty,
	output logic        q_rd,
	output logic        empty,
	input  logic        pop,
	output logic [9:0]  pixel_x,
	output logic [9:0]  pixel_y,
	output logic [15:0] pixel_color,
	output logic        last
);

	// glyph walk state
	coord_t      origin_q;
	coord_t      row_q;
	logic [7:0]  col_q;
	logic [7:0]  rows_left_q;
	logic [7:0]  width_q;
	logic [15:0] color_q;

	// current byte
	logic        busy_q;
	logic        flush_q;
	logic [7:0]  byte_q;
	logic [2:0]  bit_cnt_q;

	// held-back pixel
	logic        pend_v_q;
	pix_t        pend_q;

	// output buffer, two entries
	pix_t        obuf_q [2];
	logic        owr_q;
	logic        ord_q;
	logic [1:0]  ocnt_q;

	logic        out_space;
	logic        step;
	logic        flush_go;
	logic        live;
	coord_t      px;
	logic        in_x;
	logic        in_y;
	logic        vis;
	logic [8:0]  col_next;
	logic        wrap;
	logic        final_bit;
	logic        need_flush;
	logic        take;
	logic        push;
	pix_t        push_data;
	pix_t        new_pix;
	logic        pop_go;

	assign out_space = (ocnt_q != 2'd2);
	assign step      = busy_q && out_space;
	assign flush_go  = flush_q && out_space;
	assign live      = (rows_left_q != 8'd0);

	// clip the current bit against the visible area
	assign px   = origin_q + $signed({10'b0, col_q});
	assign in_x = !px[17] && (px[16:0] < {6'b0, lim.wlim});
	assign in_y = !row_q[17] && (row_q[16:0] < {6'b0, lim.hlim});
	assign vis  = live && byte_q[7] && in_x && in_y;

	// end of row, end of byte
	assign col_next   = {1'b0, col_q} + 9'd1;
	assign wrap       = (col_next >= {1'b0, width_q});
	assign final_bit  = (bit_cnt_q == 3'd7) || !live || ((rows_left_q == 8'd1) && wrap);
	assign need_flush = pend_v_q && vis && final_bit;

	assign take = !q_empty && ((!busy_q && !flush_q) || (step && final_bit && !need_flush));
	assign q_rd = take;

	always_comb begin
		new_pix.x     = px[9:0];
		new_pix.y     = row_q[9:0];
		new_pix.color = color_q;
		new_pix.last  = 1'b0;
	end

	// pixel write selection: at most one per cycle
	always_comb begin
		push      = 1'b0;
		push_data = pend_q;
		if (flush_go) begin
			push           = 1'b1;
			push_data.last = 1'b1;
		end else if (step) begin
			if (pend_v_q && (vis || final_bit)) begin
				push           = 1'b1;
				push_data.last = !vis;
			end else if (!pend_v_q && vis && final_bit) begin
				push           = 1'b1;
				push_data      = new_pix;
				push_data.last = 1'b1;
			end
		end
	end

	// walker and byte control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			flush_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			bit_cnt_q   <= '0;
			rows_left_q <= '0;
			width_q     <= '0;
			col_q       <= '0;
			origin_q    <= '0;
			row_q       <= '0;
			color_q     <= '0;
			byte_q      <= '0;
			pend_q      <= '0;
		end else begin
			if (flush_go) begin
				flush_q  <= 1'b0;
				pend_v_q <= 1'b0;
			end
			if (step) begin
				if (live) begin
					if (wrap) begin
						col_q       <= '0;
						row_q       <= row_q + 18'sd1;
						rows_left_q <= rows_left_q - 8'd1;
					end else begin
						col_q <= col_next[7:0];
					end
				end
				byte_q    <= {byte_q[6:0], 1'b0};
				bit_cnt_q <= bit_cnt_q + 3'd1;
				if (final_bit) begin
					busy_q   <= 1'b0;
					flush_q  <= need_flush;
					pend_v_q <= need_flush;
					if (need_flush) begin
						pend_q <= new_pix;
					end
				end else if (vis) begin
					pend_v_q <= 1'b1;
					pend_q   <= new_pix;
				end
			end
			// next item from the queue; a start item reloads the whole walk
			if (take) begin
				if (q_rdata.is_byte) begin
					busy_q    <= 1'b1;
					byte_q    <= q_rdata.data;
					bit_cnt_q <= '0;
				end else begin
					origin_q    <= q_rdata.col;
					row_q       <= q_rdata.row;
					width_q     <= q_rdata.width;
					rows_left_q <= q_rdata.rows;
					col_q       <= '0;
					color_q     <= q_rdata.color;
				end
			end
		end
	end

	// output buffer
	assign pop_go = pop && (ocnt_q != 2'd0);
	assign empty  = (ocnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			obuf_q[owr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (push) begin
				owr_q <= !owr_q;
			end
			if (pop_go) begin
				ord_q <= !ord_q;
			end
			if (push && !pop_go) begin
				ocnt_q <= ocnt_q + 2'd1;
			end else if (pop_go && !push) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
		end
	end

	assign pixel_x     = obuf_q[ord_q].x;
	assign pixel_y     = obuf_q[ord_q].y;
	assign pixel_color = obuf_q[ord_q].color;
	assign last        = obuf_q[ord_q].last;

endmodule

FILE: hdl/bitmap_glyph_pixel_emitter.sv
// ----------------------------------------------------------------------------
// bitmap_glyph_pixel_emitter
// Glyph blitter: turns a start item and packed bitmap bytes into clipped
// pixel writes.
// ----------------------------------------------------------------------------
// A start item emits nothing. A bitmap byte is walked one bit per cycle
// while the output buffer has space, stopping early when the glyph runs out
// of rows inside the byte, plus a flush step when both of the byte's final
// walked bit and an earlier bit produce a pixel. Items enter a four-entry
// queue, so input accepts continue while the walker is busy, and results
// leave through a two-entry buffer at one per cycle. Screen registers are
// clamped to 1024 and should be written only while the block is idle.
// ----------------------------------------------------------------------------
module bitmap_glyph_pixel_emitter
	import bgpe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	// items in
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [15:0] pen_x,
	input  logic [15:0] pen_y,
	input  logic [7:0]  glyph_cols,
	input  logic [7:0]  glyph_height,
	input  logic [7:0]  offset_x,
	input  logic [7:0]  offset_y,
	input  logic [7:0]  line_advance,
	input  logic [15:0] ink_color,
	input  logic [7:0]  bitmap_byte,
	// pixel writes out
	output logic        empty,
	input  logic        pop,
	output logic [9:0]  pixel_x,
	output logic [9:0]  pixel_y,
	output logic [15:0] pixel_color,
	output logic        last
);

	logic [10:0] screen_width_q;
	logic [10:0] screen_height_q;
	limits_t     lim;
	logic        q_full;
	logic        q_wr;
	op_t         q_wdata;
	logic        q_rd;
	op_t         q_rdata;
	logic        q_empty;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign lim = {clamp_limit(screen_width_q), clamp_limit(screen_height_q)};

	bgpe_front u_front (
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.pen_x        (pen_x),
		.pen_y        (pen_y),
		.glyph_cols   (glyph_cols),
		.glyph_height (glyph_height),
		.offset_x     (offset_x),
		.offset_y     (offset_y),
		.line_advance (line_advance),
		.ink_color    (ink_color),
		.bitmap_byte  (bitmap_byte),
		.q_full       (q_full),
		.q_wr         (q_wr),
		.q_wdata      (q_wdata)
	);

	bgpe_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.q_full  (q_full),
		.rd_en   (q_rd),
		.rd_data (q_rdata),
		.q_empty (q_empty)
	);

	bgpe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.lim         (lim),
		.q_rdata     (q_rdata),
		.q_empty     (q_empty),
		.q_rd        (q_rd),
		.empty       (empty),
		.pop         (pop),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last        (last)
	);

endmodule
